// ===== hw/rtl/sli_pkg.sv =====
package sli_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int CMD_W    = 2;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  typedef logic signed [VAL_W-1:0] value_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_APPEND,
    OP_INSERT,
    OP_DELETE
  } cell_op_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_t op;
    value_t   value;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/sli_in_if.sv =====
interface sli_in_if;
  import sli_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  value_t           value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);

endinterface

// ===== hw/rtl/sli_out_if.sv =====
interface sli_out_if;
  import sli_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic             dropped;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, output found, output dropped, output entry_count,
                  input ready);
  modport sink   (input valid, input found, input dropped, input entry_count,
                  output ready);

endinterface

// ===== hw/rtl/sorted_list_insert_delete_top.sv =====
// Sorted list with append, sorted insert and delete-first-match.
//
// in_ch  : valid/ready channel carrying command and signed 32-bit value.
// out_ch : valid/ready channel with one result per item: found, dropped and
//          entry_count (entries held after the operation).
//
// The list lives in a row of CAPACITY cells. Every cell compares its entry
// against the broadcast value in the same cycle and shifts left or right
// with its neighbors, so one item is taken per cycle while the receiver does
// not stall; out_ch.valid rises in the cycle after acceptance. The first
// match/greater-than search ripples through the row of cells.
//
// A full list refuses append and insert and reports dropped. Command 3 does
// nothing and reports the current count.
//
// Reset (rst_n low, synchronous) empties the list; cell contents are not
// cleared, only the entry count. When the receiver stalls, the result is
// held in the output register and one more item is not taken until it
// leaves.
module sorted_list_insert_delete_top (
  input logic        clk,
  input logic        rst_n,
  sli_in_if.sink     in_ch,
  sli_out_if.source  out_ch
);
  import sli_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             found_r;
  logic             dropped_r;
  logic [CNT_W-1:0] entry_count_r;

  logic             accept;
  logic             full;
  logic             is_add;
  cell_ctrl_t       ctrl;
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY:0]   stop;
  value_t           cell_data [CAPACITY];
  logic             found;
  logic             dropped;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(CAPACITY));
  assign is_add      = (in_ch.command == CMD_APPEND) || (in_ch.command == CMD_INSERT);

  always_comb begin
    ctrl.value = in_ch.value;
    ctrl.op    = OP_NONE;
    if (accept) begin
      case (in_ch.command)
        CMD_APPEND: ctrl.op = full ? OP_NONE : OP_APPEND;
        CMD_INSERT: ctrl.op = full ? OP_NONE : OP_INSERT;
        CMD_DELETE: ctrl.op = OP_DELETE;
        default:    ctrl.op = OP_NONE;
      endcase
    end
  end

  assign stop[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t left_d;
    value_t right_d;

    assign valid_vec[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_d = ctrl.value;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    sli_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (valid_vec[i]),
      .left_data  (left_d),
      .right_data (right_d),
      .stop_in    (stop[i]),
      .stop_out   (stop[i+1]),
      .data_q     (cell_data[i])
    );
  end

  assign found   = (ctrl.op == OP_DELETE) && stop[CAPACITY];
  assign dropped = accept && is_add && full;

  always_comb begin
    count_nxt = count_r;
    if ((ctrl.op == OP_APPEND) || (ctrl.op == OP_INSERT)) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (found) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found_r       <= found;
      dropped_r     <= dropped;
      entry_count_r <= count_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = found_r;
  assign out_ch.dropped     = dropped_r;
  assign out_ch.entry_count = entry_count_r;

endmodule

// ===== hw/rtl/sli_cell.sv =====
module sli_cell (
  input  logic               clk,
  input  sli_pkg::cell_ctrl_t ctrl,
  input  logic               valid,
  input  sli_pkg::value_t    left_data,
  input  sli_pkg::value_t    right_data,
  input  logic               stop_in,
  output logic               stop_out,
  output sli_pkg::value_t    data_q
);
  import sli_pkg::*;

  value_t data_r;
  value_t data_nxt;
  logic   own_stop;

  // stop marks the first cell where the operation takes effect; stop_in says
  // some cell to the left already did
  always_comb begin
    case (ctrl.op)
      OP_APPEND: own_stop = !valid;
      OP_INSERT: own_stop = !valid || ($signed(data_r) > $signed(ctrl.value));
      OP_DELETE: own_stop = valid && (data_r == ctrl.value);
      default:   own_stop = 1'b0;
    endcase
  end

  assign stop_out = stop_in | own_stop;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      OP_APPEND, OP_INSERT: begin
        if (stop_in) begin
          data_nxt = left_data;
        end else if (own_stop) begin
          data_nxt = ctrl.value;
        end
      end
      OP_DELETE: begin
        if (stop_out) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// ===== hw/rtl/sli_checker.sv =====
module sli_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      found,
  input logic                      dropped,
  input logic [sli_pkg::CNT_W-1:0] entry_count
);
  import sli_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(dropped)
      && $stable(entry_count))
    else $error("result changed while stalled");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(found && dropped))
    else $error("found and dropped both set");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dropped |-> entry_count == CNT_W'(CAPACITY))
    else $error("dropped while list not full");

  a_found_lt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> entry_count < CNT_W'(CAPACITY))
    else $error("found with list still full");

endmodule

bind sorted_list_insert_delete_top sli_checker u_sli_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .found       (out_ch.found),
  .dropped     (out_ch.dropped),
  .entry_count (out_ch.entry_count)
);

// ===== tb/tb_sorted_list_insert_delete_top.sv =====
`timescale 1ns / 100ps

module tb_sorted_list_insert_delete_top;
  import sli_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int RANDOM_ITEMS = 1830;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 5;

  typedef struct {
    logic             found;
    logic             dropped;
    logic [CNT_W-1:0] entry_count;
  } list_outcome_t;

  // Shadow copy of the list; predicts one outcome per accepted item.
  class list_shadow;
    value_t        stored[CAPACITY];
    int unsigned   held;
    list_outcome_t outcomes_due[$];
    int            mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    function void apply_command(logic [CMD_W-1:0] cmd, value_t v);
      list_outcome_t o;
      int            pos;
      int            i;
      o = '{found: 1'b0, dropped: 1'b0, entry_count: '0};
      if (cmd == CMD_APPEND || cmd == CMD_INSERT) begin
        if (held >= CAPACITY) begin
          o.dropped = 1'b1;
        end else begin
          pos = held;
          if (cmd == CMD_INSERT) begin
            // first strictly greater entry; equal values stay ahead
            i = 0;
            while (i < held && pos == held) begin
              if (stored[i] > v) pos = i;
              i++;
            end
          end
          for (i = held; i > pos; i--) stored[i] = stored[i-1];
          stored[pos] = v;
          held++;
        end
      end else if (cmd == CMD_DELETE) begin
        pos = -1;
        for (i = 0; i < held; i++) begin
          if (pos < 0 && stored[i] == v) pos = i;
        end
        if (pos >= 0) begin
          for (i = pos; i + 1 < held; i++) stored[i] = stored[i+1];
          held--;
          o.found = 1'b1;
        end
      end
      o.entry_count = held[CNT_W-1:0];
      outcomes_due.push_back(o);
    endfunction

    function void report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void check_result(logic f, logic d, logic [CNT_W-1:0] n);
      list_outcome_t want;
      if (outcomes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected item found=%0b dropped=%0b entry_count=%0d",
                                  f, d, n));
        return;
      end
      want = outcomes_due.pop_front();
      if (f !== want.found || d !== want.dropped || n !== want.entry_count)
        report_mismatch($sformatf(
          "expected found=%0b dropped=%0b entry_count=%0d, got found=%0b dropped=%0b entry_count=%0d",
          want.found, want.dropped, want.entry_count, f, d, n));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   steady = 1'b0;
  bit   hold_results = 1'b0;

  list_shadow shadow;

  sli_in_if  in_ch ();
  sli_out_if out_ch ();

  sorted_list_insert_delete_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_ch.valid && in_ch.ready) shadow.apply_command(in_ch.command, in_ch.value);
      if (out_ch.valid && out_ch.ready)
        shadow.check_result(out_ch.found, out_ch.dropped, out_ch.entry_count);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("sorted_list_insert_delete_top test failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      out_ch.ready <= steady || ($urandom_range(99) >= 35);
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input value_t v);
    while (!steady && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.value   <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (shadow.outcomes_due.size() != 0) @(posedge clk);
  endtask

  function automatic value_t pick_value(input bit for_delete);
    int unsigned r;
    r = $urandom_range(99);
    if (for_delete && shadow.held != 0 && r < 60)
      return shadow.stored[$urandom_range(shadow.held - 1)];
    if (r < 45) return int'($urandom_range(16)) - 8;
    if (r < 65) begin
      case ($urandom_range(5))
        0: return 32'sh8000_0000;
        1: return 32'sh8000_0001;
        2: return -1;
        3: return 0;
        4: return 32'sh7fff_fffe;
        default: return 32'sh7fff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  initial begin : stimulus
    int          sent;
    int unsigned seg_len;
    int unsigned add_pct;
    logic [CMD_W-1:0] cmd;

    shadow = new();
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_APPEND;
    in_ch.value   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-list delete, extremes, equal values, miss, unused command
    send_item(CMD_DELETE, 0);
    send_item(CMD_APPEND, 32'sh7fff_ffff);
    send_item(CMD_APPEND, 32'sh8000_0000);
    send_item(CMD_INSERT, -1);
    send_item(CMD_INSERT, 0);
    send_item(CMD_INSERT, 0);
    send_item(CMD_INSERT, 32'sh8000_0000);
    send_item(CMD_INSERT, 32'sh7fff_ffff);
    send_item(CMD_INSERT, 32'sh5555_aaaa);
    send_item(CMD_DELETE, 0);
    send_item(CMD_DELETE, 5);
    send_item(CMD_DELETE, 32'sh8000_0000);
    send_item(CMD_NOP, 32'shffff_ffff);
    send_item(CMD_APPEND, -7);
    send_item(CMD_DELETE, 32'sh7fff_ffff);

    // random: segments that lean toward filling, emptying or churning the list
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(60, 15);
      case ($urandom_range(2))
        0: add_pct = 85;
        1: add_pct = 20;
        default: add_pct = 50;
      endcase
      repeat (seg_len) begin
        if ($urandom_range(99) < 2) cmd = CMD_NOP;
        else if ($urandom_range(99) < add_pct) cmd = $urandom_range(1) ? CMD_INSERT : CMD_APPEND;
        else cmd = CMD_DELETE;
        send_item(cmd, pick_value(cmd == CMD_DELETE));
        if (cmd != CMD_NOP) begin
          sent++;
          case (sent)
            400:  hold_results = 1'b1;
            900:  wait_drained();
            1200: steady = 1'b1;
            1400: steady = 1'b0;
            default: ;
          endcase
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.outcomes_due.size() == 0) begin
      $display("sorted_list_insert_delete_top test passed");
    end else begin
      $display("sorted_list_insert_delete_top test failed");
    end
    $finish;
  end

endmodule
